@@ src/srfc_pkg.sv @@
// shared types and constants for the sensor response frame checker
package srfc_pkg;

    // frame layout
    localparam int FRAME_LEN = 9;
    localparam int SUM_SPAN  = 6;
    localparam int CNT_W     = $clog2(FRAME_LEN + 1);

    localparam logic [7:0] HEAD_MARK = 8'hAA;
    localparam logic [7:0] TAIL_MARK = 8'hBB;

    // result packing on the output bus
    localparam int STATUS_W = 3;
    localparam int WORD_W   = 16;
    localparam int RES_W    = STATUS_W + 2 * WORD_W;
    localparam int M_DATA_W = ((RES_W + 7) / 8) * 8;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 3'd0,
        ST_SHORT = 3'd1,
        ST_FRAME = 3'd2,
        ST_SUM   = 3'd3,
        ST_CMD   = 3'd4
    } status_t;

    typedef struct packed {
        logic [WORD_W-1:0] pm25_value;
        logic [WORD_W-1:0] pm10_value;
        status_t           status;
    } result_t;

endpackage

@@ src/srfc_frame_check.sv @@
// frame accumulator: stores the first bytes of a chunk, keeps the sum, checks on chunk end
module srfc_frame_check
    import srfc_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          step_en,      // one byte is processed this cycle
    input  logic [7:0]    byte_in,
    input  logic          last_in,
    input  logic [7:0]    expected_cmd,
    output result_t       res           // valid when step_en and last_in
);

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [WORD_W-1:0] sum_reg;
    logic [WORD_W-1:0] sum_next;
    logic [7:0]        bytes_reg [FRAME_LEN];

    logic              room;
    logic              sum_add;
    logic [CNT_W-1:0]  count_inc;
    logic [WORD_W-1:0] sum_inc;
    logic [7:0]        tail_byte;
    logic [WORD_W-1:0] chk_word;

    // count, sum and tail byte as they stand after this byte
    always_comb begin
        room      = (count_reg < CNT_W'(FRAME_LEN));
        sum_add   = (count_reg < CNT_W'(SUM_SPAN)) || (count_reg == CNT_W'(FRAME_LEN - 1));
        count_inc = room ? count_reg + CNT_W'(1) : count_reg;
        sum_inc   = (room && sum_add) ? sum_reg + WORD_W'(byte_in) : sum_reg;
        tail_byte = (count_reg == CNT_W'(FRAME_LEN - 1)) ? byte_in : bytes_reg[FRAME_LEN-1];
        chk_word  = {bytes_reg[6], bytes_reg[7]};
    end

    // frame checks in priority order
    always_comb begin
        res = '0;
        if (count_inc != CNT_W'(FRAME_LEN)) begin
            res.status = ST_SHORT;
        end else if (bytes_reg[0] != HEAD_MARK || tail_byte != TAIL_MARK) begin
            res.status = ST_FRAME;
        end else if (sum_inc != chk_word) begin
            res.status = ST_SUM;
        end else if (bytes_reg[1] != expected_cmd) begin
            res.status = ST_CMD;
        end else begin
            res.status     = ST_OK;
            res.pm10_value = {bytes_reg[2], bytes_reg[3]};
            res.pm25_value = {bytes_reg[4], bytes_reg[5]};
        end
    end

    // advance count and sum per byte, clear them at chunk end
    always_comb begin
        count_next = count_reg;
        sum_next   = sum_reg;
        if (step_en) begin
            count_next = last_in ? '0 : count_inc;
            sum_next   = last_in ? '0 : sum_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            sum_reg   <= '0;
        end else begin
            count_reg <= count_next;
            sum_reg   <= sum_next;
        end
    end

    // frame byte store, no reset
    always_ff @(posedge aclk) begin
        if (step_en && room) begin
            bytes_reg[count_reg] <= byte_in;
        end
    end

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(FRAME_LEN))
        else $error("byte count past frame length");

    a_clear_on_end: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && last_in |=> count_reg == '0 && sum_reg == '0)
        else $error("accumulator not cleared after chunk end");

    a_hold_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !step_en |=> $stable(count_reg) && $stable(sum_reg))
        else $error("accumulator moved without a byte");

endmodule

@@ src/sensor_response_frame_checker.sv @@
// top level: input register, frame accumulator and result register
//
//  channel   dir  tdata                                  side band
//  s_axis    in   [7:0] rx_byte                          tlast = chunk_end
//  m_axis    out  [2:0] status, [18:3] pm10_value,       none
//                 [34:19] pm25_value, [39:35] zero
//  cfg       in   cfg_wdata = expected_command           cfg_we
//
// one byte per cycle while no waiting result holds back a tlast byte; each
// byte passes the input register and the accumulator, and a tlast byte's
// result is then loaded into the result register. reset clears count,
// sum, command and both valid flags. a waiting result stalls only a
// following tlast byte; other bytes keep flowing into the accumulator.
module sensor_response_frame_checker
    import srfc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // input stream
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,   // [7:0] rx_byte
    input  logic                s_axis_tlast,   // chunk_end
    // result stream
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [M_DATA_W-1:0] m_axis_tdata,   // status, pm10_value, pm25_value, zero pad
    // configuration
    input  logic                cfg_we,
    input  logic [7:0]          cfg_wdata
);

    logic          in_valid_reg;
    logic          in_valid_next;
    logic [7:0]    in_byte_reg;
    logic          in_last_reg;
    logic [7:0]    cmd_reg;
    logic          m_valid_reg;
    logic          m_valid_next;
    result_t       m_res_reg;

    logic          s_fire;
    logic          proc_ok;
    logic          proc;
    logic          load;
    result_t       chk_res;

    // handshake and pipeline advance
    always_comb begin
        proc_ok       = !in_last_reg || !m_valid_reg || m_axis_tready;
        proc          = in_valid_reg && proc_ok;
        load          = proc && in_last_reg;
        s_axis_tready = !in_valid_reg || proc_ok;
        s_fire        = s_axis_tvalid && s_axis_tready;
        in_valid_next = s_fire ? 1'b1 : (proc ? 1'b0 : in_valid_reg);
        m_valid_next  = load ? 1'b1 : (m_axis_tready ? 1'b0 : m_valid_reg);
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            cmd_reg      <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_we) begin
                cmd_reg <= cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        if (load) begin
            m_res_reg <= chk_res;
        end
    end

    srfc_frame_check u_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step_en      (proc),
        .byte_in      (in_byte_reg),
        .last_in      (in_last_reg),
        .expected_cmd (cmd_reg),
        .res          (chk_res)
    );

    // output bus
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = M_DATA_W'(m_res_reg);

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> m_axis_tvalid)
        else $error("chunk end gave no result");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_res_reg.status != ST_OK |->
            m_res_reg.pm10_value == '0 && m_res_reg.pm25_value == '0)
        else $error("failed frame carries measurement words");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_res_reg))
        else $error("pending result overwritten");

endmodule

@@ verif/tb_sensor_response_frame_checker.sv @@
// self-checking testbench for the sensor response frame checker
`timescale 1ns / 1ps

module tb_sensor_response_frame_checker;
    import srfc_pkg::*;

    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_BYTES  = 220;
    localparam int HOLD_CYCLES  = 300;
    localparam int TIMEOUT_NS   = 1_000_000;

    typedef logic [7:0] byte_q_t[$];

    // ways a random frame gets damaged
    typedef enum int {
        FLAW_HEAD,
        FLAW_TAIL,
        FLAW_SUM,
        FLAW_CMD,
        FLAW_NONE
    } flaw_t;

    logic                aclk;
    logic                aresetn;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [7:0]          s_axis_tdata;   // [7:0] rx_byte
    logic                s_axis_tlast;   // chunk_end
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [M_DATA_W-1:0] m_axis_tdata;   // status, pm10_value, pm25_value, zero pad
    logic                cfg_we;
    logic [7:0]          cfg_wdata;

    // frame tracker copy of the block state
    logic [CNT_W-1:0] trk_count;
    logic [7:0]       trk_frame [FRAME_LEN];
    logic [15:0]      trk_sum;
    logic [7:0]       trk_command;

    result_t pending_results[$];
    logic [7:0] cur_command;

    int  error_count;
    int  bytes_sent;
    int  chunks_sent;
    int  results_seen;
    int  command_writes;
    int  status_seen [5];
    bit  tx_idle_on;
    bit  rx_idle_on;
    int  hold_request;

    sensor_response_frame_checker i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // run limit
    initial begin
        #(TIMEOUT_NS);
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    // update the tracked frame with one accepted byte, queue a result on chunk end
    task automatic track_rx_byte(input logic [7:0] rx, input logic is_last);
        result_t r;
        if (trk_count < FRAME_LEN) begin
            trk_frame[trk_count] = rx;
            if (trk_count < SUM_SPAN || trk_count == FRAME_LEN - 1)
                trk_sum = trk_sum + 16'(rx);
            trk_count = trk_count + 1'b1;
        end
        if (is_last) begin
            r = '0;
            if (trk_count < FRAME_LEN) begin
                r.status = ST_SHORT;
            end else if (trk_frame[0] != HEAD_MARK || trk_frame[FRAME_LEN-1] != TAIL_MARK) begin
                r.status = ST_FRAME;
            end else if (trk_sum != {trk_frame[6], trk_frame[7]}) begin
                r.status = ST_SUM;
            end else if (trk_frame[1] != trk_command) begin
                r.status = ST_CMD;
            end else begin
                r.status     = ST_OK;
                r.pm10_value = {trk_frame[2], trk_frame[3]};
                r.pm25_value = {trk_frame[4], trk_frame[5]};
            end
            pending_results.push_back(r);
            trk_count = '0;
            trk_sum   = '0;
        end
    endtask

    // tracking on accepted transfers and result checking
    always @(posedge aclk) begin : scoreboard
        result_t got;
        result_t want;
        if (!aresetn) begin
            trk_count   = '0;
            trk_sum     = '0;
            trk_command = '0;
        end else begin
            if (cfg_we)
                trk_command = cfg_wdata;
            if (s_axis_tvalid && s_axis_tready)
                track_rx_byte(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready) begin
                got = result_t'(m_axis_tdata[RES_W-1:0]);
                if (m_axis_tdata[M_DATA_W-1:RES_W] != '0)
                    report_mismatch($sformatf("pad bits %0h not zero",
                                              m_axis_tdata[M_DATA_W-1:RES_W]));
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf("result %0h with nothing expected",
                                              m_axis_tdata));
                end else begin
                    want = pending_results.pop_front();
                    results_seen++;
                    if (want.status <= ST_CMD)
                        status_seen[want.status]++;
                    if (got.status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  got.status, want.status));
                    if (got.pm10_value !== want.pm10_value)
                        report_mismatch($sformatf("pm10 %04h, expected %04h",
                                                  got.pm10_value, want.pm10_value));
                    if (got.pm25_value !== want.pm25_value)
                        report_mismatch($sformatf("pm25 %04h, expected %04h",
                                                  got.pm25_value, want.pm25_value));
                end
            end
        end
    end

    // result side ready: random stall bursts and a requested long hold-off
    initial begin : result_ready
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        m_axis_tready = 1'b1;
        forever begin
            @(negedge aclk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 12) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // one byte transfer, with an optional idle burst in front
    task automatic send_byte(input logic [7:0] rx, input logic is_last);
        int gap;
        @(negedge aclk);
        if (tx_idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 12);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= rx;
        s_axis_tlast  <= is_last;
        do @(posedge aclk); while (!s_axis_tready);
        bytes_sent++;
    endtask

    task automatic send_chunk(input byte_q_t chunk);
        foreach (chunk[i])
            send_byte(chunk[i], i == chunk.size() - 1);
        chunks_sent++;
    endtask

    // well-formed reply with a matching checksum
    function automatic byte_q_t make_frame(input logic [7:0] cmd, input logic [15:0] pm10,
                                           input logic [15:0] pm25);
        byte_q_t f;
        logic [15:0] sum;
        f = '{HEAD_MARK, cmd, pm10[15:8], pm10[7:0], pm25[15:8], pm25[7:0],
              8'h00, 8'h00, TAIL_MARK};
        sum = '0;
        for (int i = 0; i < SUM_SPAN; i++)
            sum = sum + 16'(f[i]);
        sum = sum + 16'(f[FRAME_LEN-1]);
        f[6] = sum[15:8];
        f[7] = sum[7:0];
        return f;
    endfunction

    // mostly valid or lightly damaged frames, some short chunks and noise
    task automatic send_random_chunk();
        byte_q_t     c;
        int          pick;
        int          n;
        flaw_t       flaw;
        logic [15:0] p10;
        logic [15:0] p25;
        pick = $urandom_range(0, 99);
        p10  = 16'($urandom);
        p25  = 16'($urandom);
        if ($urandom_range(0, 9) == 0)
            p10 = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        if ($urandom_range(0, 9) == 0)
            p25 = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        if (pick < 60) begin
            n    = $urandom_range(0, 9);
            flaw = (n < 4) ? flaw_t'(n) : FLAW_NONE;
            if (flaw == FLAW_CMD)
                c = make_frame(cur_command ^ 8'($urandom_range(1, 255)), p10, p25);
            else
                c = make_frame(cur_command, p10, p25);
            case (flaw)
                FLAW_HEAD: c[0] = HEAD_MARK ^ 8'($urandom_range(1, 255));
                FLAW_TAIL: c[FRAME_LEN-1] = TAIL_MARK ^ 8'($urandom_range(1, 255));
                FLAW_SUM:  c[6 + $urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
                default:   ;
            endcase
            // trailing bytes past the frame
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 4)) c.push_back(8'($urandom));
        end else if (pick < 80) begin
            c = make_frame(cur_command, p10, p25);
            n = $urandom_range(1, FRAME_LEN - 1);
            while (c.size() > n)
                void'(c.pop_back());
        end else begin
            c = {};
            repeat ($urandom_range(1, 14)) c.push_back(8'($urandom));
            if ($urandom_range(0, 2) == 0)
                c[0] = HEAD_MARK;
        end
        send_chunk(c);
    endtask

    // wait for the block to go quiet before touching the register
    task automatic drain();
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_command(input logic [7:0] cmd);
        drain();
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= cmd;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        cur_command = cmd;
        command_writes++;
    endtask

    // extremes of the words, bytes past nine, a one-byte chunk, check order
    task automatic test_directed();
        byte_q_t f;
        f = make_frame(8'h00, 16'hFFFF, 16'h0000);
        f.push_back(8'hFF);
        f.push_back(8'h00);
        send_chunk(f);
        f = '{8'hFF};
        send_chunk(f);
        // header, tail and checksum all broken: header check reports first
        f = make_frame(8'h00, 16'h1234, 16'h5678);
        f[0] = 8'h00;
        f[FRAME_LEN-1] = 8'h00;
        send_chunk(f);
    endtask

    // random traffic under several command settings, extremes included
    task automatic test_command_sweep();
        logic [7:0] cmds [5];
        int start;
        cmds = '{8'hFF, 8'h00, 8'($urandom), 8'($urandom), 8'($urandom)};
        foreach (cmds[k]) begin
            write_command(cmds[k]);
            tx_idle_on = $urandom_range(0, 3) != 0;
            rx_idle_on = $urandom_range(0, 3) != 0;
            start = bytes_sent;
            while (bytes_sent - start < PHASE_BYTES)
                send_random_chunk();
        end
    endtask

    // receiver holds off while the sender keeps offering chunks
    task automatic test_backpressure();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        hold_request = HOLD_CYCLES;
        repeat (30) send_random_chunk();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // closing stretch at full rate with no idling
    task automatic test_full_rate();
        int start;
        write_command(8'($urandom));
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        start = bytes_sent;
        while (bytes_sent - start < PHASE_BYTES)
            send_random_chunk();
    endtask

    initial begin
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        cur_command   = '0;
        error_count    = 0;
        bytes_sent     = 0;
        chunks_sent    = 0;
        results_seen   = 0;
        command_writes = 0;
        hold_request   = 0;
        status_seen    = '{default: 0};
        tx_idle_on     = 1'b1;
        rx_idle_on     = 1'b1;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_command_sweep();
        test_backpressure();
        test_full_rate();

        drain();
        $display("sent %0d bytes in %0d chunks over %0d command settings, %0d results",
                 bytes_sent, chunks_sent, command_writes + 1, results_seen);
        $display("ok %0d, short %0d, header/tail %0d, checksum %0d, command %0d",
                 status_seen[ST_OK], status_seen[ST_SHORT], status_seen[ST_FRAME],
                 status_seen[ST_SUM], status_seen[ST_CMD]);
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches", error_count);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ sim.f @@
src/srfc_pkg.sv
src/srfc_frame_check.sv
src/sensor_response_frame_checker.sv
verif/tb_sensor_response_frame_checker.sv
